// ===== design/mcc_pkg.sv =====
// Shared types, constants and helper functions for the multicycle CPU core.
`default_nettype none

package mcc_pkg;

  // Machine sizing
  localparam int MEM_DEPTH  = 256;
  localparam int DATA_BASE  = 128;
  localparam int NUM_REGS   = 8;
  localparam int WORD_WIDTH = 16;

  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int RF_AW     = $clog2(NUM_REGS);
  localparam int DATA_SPAN = (DATA_BASE < MEM_DEPTH) ? (MEM_DEPTH - DATA_BASE) : 0;

  // Fixed field widths of the stream items
  localparam int PC_W     = 8;
  localparam int FIELD_W  = 16;
  localparam int CNT_W    = 32;
  localparam int PLEN_W   = 8;
  localparam int MODE_W   = 2;
  localparam int FSM_W    = 4;
  localparam int CLASS_W  = 3;
  localparam int ADDR_W   = 8;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 144;
  localparam int M_USER_W = 5;

  typedef logic [WORD_WIDTH-1:0] word_t;

  // Control states
  typedef enum logic [FSM_W-1:0] {
    S_FETCH  = 4'd0,
    S_DECODE = 4'd1,
    S_EXEC   = 4'd2,
    S_WRITE  = 4'd3,
    S_MADDR  = 4'd4,
    S_MREAD  = 4'd5,
    S_MWB    = 4'd6,
    S_MWRITE = 4'd7,
    S_BRANCH = 4'd8,
    S_JUMP   = 4'd9
  } fsm_t;

  // Item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 2'd0,
    MODE_MEM_WR = 2'd1,
    MODE_MEM_RD = 2'd2,
    MODE_REG_RD = 2'd3
  } mode_t;

  // Opcodes
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_JUMP  = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // R-type function codes
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Completed instruction classes
  localparam logic [CLASS_W-1:0] CLS_RTYPE   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_ADDI    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_BEQ     = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_LW      = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_SW      = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_JUMP    = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_INVALID = 3'd6;

  // Architectural registers apart from the register file and memory
  typedef struct packed {
    logic [PC_W-1:0]  pc;
    word_t            ir;
    word_t            a;
    word_t            b;
    word_t            alu;
    word_t            mdr;
    fsm_t             fsm;
    logic [CNT_W-1:0] cyc;
    logic [CNT_W-1:0] icnt;
  } arch_t;

  localparam arch_t ARCH_RESET = '{
    pc:   '0,
    ir:   '0,
    a:    '0,
    b:    '0,
    alu:  '0,
    mdr:  '0,
    fsm:  S_FETCH,
    cyc:  '0,
    icnt: '0
  };

  typedef struct packed {
    mode_t             mode;
    logic [ADDR_W-1:0] addr;
    logic [FIELD_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    word_t             data;
  } mem_wr_t;

  typedef struct packed {
    logic             we;
    logic [RF_AW-1:0] idx;
    word_t            data;
  } rf_wr_t;

  typedef struct packed {
    logic                halted;
    logic [PC_W-1:0]     pc;
    logic [FSM_W-1:0]    fsm;
    logic [FIELD_W-1:0]  ir;
    logic [FIELD_W-1:0]  alu;
    logic [FIELD_W-1:0]  mdr;
    logic [CNT_W-1:0]    cyc;
    logic [CNT_W-1:0]    icnt;
    logic                completed;
    logic [CLASS_W-1:0]  cls;
    logic [FIELD_W-1:0]  read_data;
  } result_t;

  typedef struct packed {
    logic              ok;
    logic [MEM_AW-1:0] idx;
  } data_loc_t;

  // Map a data offset to a memory index above the data base
  function automatic data_loc_t data_loc(word_t off);
    data_loc_t r;
    r.ok  = (DATA_SPAN > 0) && !off[WORD_WIDTH-1] && (off < word_t'(DATA_SPAN));
    r.idx = MEM_AW'(DATA_BASE) + off[MEM_AW-1:0];
    return r;
  endfunction

  // Instruction class for the completion report
  function automatic logic [CLASS_W-1:0] class_of(logic [3:0] op);
    logic [CLASS_W-1:0] c;
    case (op)
      OP_RTYPE: c = CLS_RTYPE;
      OP_ADDI:  c = CLS_ADDI;
      OP_BEQ:   c = CLS_BEQ;
      OP_LW:    c = CLS_LW;
      OP_SW:    c = CLS_SW;
      OP_JUMP:  c = CLS_JUMP;
      default:  c = CLS_INVALID;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/mcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/mcc_step.sv =====
// Next-state logic of the processor for one item: control FSM, ALU and host access.
`default_nettype none

module mcc_step (
  input  wire mcc_pkg::arch_t             cur,
  input  wire mcc_pkg::item_t             item,
  input  wire logic [mcc_pkg::PLEN_W-1:0] plen,
  input  wire mcc_pkg::word_t             mem_word,
  input  wire mcc_pkg::word_t             rf_a,
  input  wire mcc_pkg::word_t             rf_b,
  output mcc_pkg::arch_t                  nxt,
  output mcc_pkg::mem_wr_t                mem_wr,
  output mcc_pkg::rf_wr_t                 rf_wr,
  output mcc_pkg::result_t                res
);

  always_comb begin
    logic [3:0]               op;
    logic [2:0]               rt;
    logic [2:0]               rd;
    logic [2:0]               funct;
    mcc_pkg::word_t           imm;
    mcc_pkg::data_loc_t       loc;
    mcc_pkg::fsm_t            fsm_n;
    logic                     run;

    op    = cur.ir[15:12];
    rt    = cur.ir[8:6];
    rd    = cur.ir[5:3];
    funct = cur.ir[2:0];
    imm   = {{(mcc_pkg::WORD_WIDTH-6){cur.ir[5]}}, cur.ir[5:0]};
    loc   = mcc_pkg::data_loc(cur.alu);
    fsm_n = mcc_pkg::S_FETCH;
    run   = 1'b0;

    nxt    = cur;
    mem_wr = '0;
    rf_wr  = '0;
    res    = '0;

    // Decode the item kind
    unique case (item.mode)
      mcc_pkg::MODE_TICK: begin
        if (cur.fsm == mcc_pkg::S_FETCH && cur.pc >= plen) begin
          res.halted = 1'b1;
        end else begin
          run = 1'b1;
        end
      end
      mcc_pkg::MODE_MEM_WR: begin
        if (int'(item.addr) < mcc_pkg::MEM_DEPTH) begin
          mem_wr.we   = 1'b1;
          mem_wr.addr = item.addr[mcc_pkg::MEM_AW-1:0];
          mem_wr.data = mcc_pkg::word_t'(item.data);
        end
      end
      mcc_pkg::MODE_MEM_RD: res.read_data = mem_word[mcc_pkg::FIELD_W-1:0];
      mcc_pkg::MODE_REG_RD: res.read_data = rf_a[mcc_pkg::FIELD_W-1:0];
    endcase

    // Advance the control machine by one state
    if (run) begin
      unique case (cur.fsm)
        mcc_pkg::S_FETCH: begin
          nxt.ir  = mem_word;
          nxt.alu = mcc_pkg::word_t'(cur.pc) + mcc_pkg::word_t'(1);
          nxt.pc  = cur.pc + 8'd1;
          fsm_n   = mcc_pkg::S_DECODE;
        end
        mcc_pkg::S_DECODE: begin
          nxt.a   = rf_a;
          nxt.b   = rf_b;
          nxt.alu = mcc_pkg::word_t'(cur.pc) + imm;
          if (op == mcc_pkg::OP_RTYPE || op == mcc_pkg::OP_ADDI) begin
            fsm_n = mcc_pkg::S_EXEC;
          end else if (op == mcc_pkg::OP_LW || op == mcc_pkg::OP_SW) begin
            fsm_n = mcc_pkg::S_MADDR;
          end else if (op == mcc_pkg::OP_BEQ) begin
            fsm_n = mcc_pkg::S_BRANCH;
          end else if (op == mcc_pkg::OP_JUMP) begin
            fsm_n = mcc_pkg::S_JUMP;
          end else begin
            fsm_n = mcc_pkg::S_FETCH;
          end
        end
        mcc_pkg::S_EXEC: begin
          if (op == mcc_pkg::OP_RTYPE) begin
            unique case (funct)
              mcc_pkg::FN_ADD: nxt.alu = cur.a + cur.b;
              mcc_pkg::FN_SUB: nxt.alu = cur.a - cur.b;
              mcc_pkg::FN_AND: nxt.alu = cur.a & cur.b;
              mcc_pkg::FN_OR:  nxt.alu = cur.a | cur.b;
              default:         nxt.alu = '0;
            endcase
          end else if (op == mcc_pkg::OP_ADDI) begin
            nxt.alu = cur.a + imm;
          end else begin
            nxt.alu = '0;
          end
          fsm_n = mcc_pkg::S_WRITE;
        end
        mcc_pkg::S_WRITE: begin
          rf_wr.we   = 1'b1;
          rf_wr.idx  = (op == mcc_pkg::OP_RTYPE) ? rd : rt;
          rf_wr.data = cur.alu;
        end
        mcc_pkg::S_MADDR: begin
          nxt.alu = cur.a + imm;
          fsm_n   = (op == mcc_pkg::OP_LW) ? mcc_pkg::S_MREAD : mcc_pkg::S_MWRITE;
        end
        mcc_pkg::S_MREAD: begin
          if (loc.ok) begin
            nxt.mdr = mem_word;
          end
          fsm_n = mcc_pkg::S_MWB;
        end
        mcc_pkg::S_MWB: begin
          rf_wr.we   = 1'b1;
          rf_wr.idx  = rt;
          rf_wr.data = cur.mdr;
        end
        mcc_pkg::S_MWRITE: begin
          if (loc.ok) begin
            mem_wr.we   = 1'b1;
            mem_wr.addr = loc.idx;
            mem_wr.data = cur.b;
          end
        end
        mcc_pkg::S_BRANCH: begin
          if (cur.a == cur.b) begin
            nxt.pc = cur.alu[mcc_pkg::PC_W-1:0];
          end
        end
        mcc_pkg::S_JUMP: nxt.pc = cur.ir[mcc_pkg::PC_W-1:0];
        default:         fsm_n = mcc_pkg::S_FETCH;
      endcase

      nxt.fsm = fsm_n;
      nxt.cyc = cur.cyc + 32'd1;
      // Count a finished instruction on the return to fetch
      if (fsm_n == mcc_pkg::S_FETCH && cur.fsm != mcc_pkg::S_FETCH) begin
        nxt.icnt      = cur.icnt + 32'd1;
        res.completed = 1'b1;
        res.cls       = mcc_pkg::class_of(op);
      end
    end

    // Report the state after this item
    res.pc   = nxt.pc;
    res.fsm  = nxt.fsm;
    res.ir   = nxt.ir[mcc_pkg::FIELD_W-1:0];
    res.alu  = nxt.alu[mcc_pkg::FIELD_W-1:0];
    res.mdr  = nxt.mdr[mcc_pkg::FIELD_W-1:0];
    res.cyc  = nxt.cyc;
    res.icnt = nxt.icnt;
  end

endmodule

`default_nettype wire

// ===== design/multicycle_cpu_core.sv =====
// Top level of the multicycle CPU core: item stream in, state report stream out.
//
//   channel  | role       | handshake           | contents
//   ---------+------------+---------------------+----------------------------------------
//   s_*      | items in   | s_tvalid / s_tready | tuser mode; tdata address, data
//   m_*      | reports out| m_tvalid / m_tready | tuser flags; tdata pc..read_data
//   cfg_*    | register   | cfg_we              | cfg_wdata = program length
//
// One item per clock sustained while reports are not stalled. An accepted item
// waits in the input register while its memory and register-file reads are in
// flight (both RAMs have registered reads), then is executed and its report is
// registered in the output register that drives m_tvalid. Reads that hit a
// write of the item ahead are bypassed. Reset (rst, synchronous) clears all
// architectural state; memory and register file read as zero through per-entry
// valid bits, so no clearing pass is needed. A stalled report holds the item
// behind it in the input register and drops s_tready only when both are full.
`default_nettype none

module multicycle_cpu_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: address[7:0], data[15:0]
  input  wire logic [mcc_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser from bit 0: mode[1:0]
  input  wire logic [mcc_pkg::MODE_W-1:0]   s_tuser,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // m_tdata from bit 0: pc_now[7:0], fsm_now[3:0], ir_now[15:0], alu_out_now[15:0],
  // mdr_now[15:0], cycle_total[31:0], instr_total[31:0], read_data[15:0], zero pad
  output logic      [mcc_pkg::M_DATA_W-1:0] m_tdata,
  // m_tuser from bit 0: halted, completed, completed_class[2:0]
  output logic      [mcc_pkg::M_USER_W-1:0] m_tuser,
  input  wire logic                         cfg_we,
  input  wire logic [mcc_pkg::PLEN_W-1:0]   cfg_wdata
);

  localparam int MAW = mcc_pkg::MEM_AW;
  localparam int RAW = mcc_pkg::RF_AW;

  // Handshake and stage control
  logic               accept;
  logic               exec_fire;
  logic               r_valid;
  mcc_pkg::item_t     r_item;
  mcc_pkg::item_t     in_item;
  logic               out_valid;
  mcc_pkg::result_t   out_res;

  logic [mcc_pkg::PLEN_W-1:0] plen;

  // Architectural state
  mcc_pkg::arch_t     arch;
  mcc_pkg::arch_t     arch_next;
  mcc_pkg::arch_t     step_arch;
  mcc_pkg::mem_wr_t   step_mem_wr;
  mcc_pkg::rf_wr_t    step_rf_wr;
  mcc_pkg::result_t   step_res;
  logic               mem_we;
  logic               rf_we;

  // Memory read path
  logic [mcc_pkg::MEM_DEPTH-1:0] mem_vld;
  logic [MAW-1:0]     mem_raddr;
  logic               mem_rok;
  mcc_pkg::data_loc_t in_loc;
  logic               mem_byp_next;
  logic               mem_zero_next;
  logic               mem_byp;
  logic               mem_zero;
  mcc_pkg::word_t     mem_byp_data;
  mcc_pkg::word_t     mem_q;
  mcc_pkg::word_t     mem_word;

  // Register file read path
  logic [mcc_pkg::NUM_REGS-1:0] rf_vld;
  logic [RAW-1:0]     rfa_raddr;
  logic [RAW-1:0]     rfb_raddr;
  logic               rfa_byp_next;
  logic               rfb_byp_next;
  logic               rfa_byp;
  logic               rfb_byp;
  logic               rfa_zero;
  logic               rfb_zero;
  mcc_pkg::word_t     rf_byp_data;
  mcc_pkg::word_t     rfa_q;
  mcc_pkg::word_t     rfb_q;
  mcc_pkg::word_t     rfa_word;
  mcc_pkg::word_t     rfb_word;

  assign in_item.mode = mcc_pkg::mode_t'(s_tuser);
  assign in_item.addr = s_tdata[mcc_pkg::ADDR_W-1:0];
  assign in_item.data = s_tdata[mcc_pkg::S_DATA_W-1:mcc_pkg::ADDR_W];

  assign exec_fire = r_valid && (!out_valid || m_tready);
  assign s_tready  = !r_valid || exec_fire;
  assign accept    = s_tvalid && s_tready;

  // Program length register
  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
    end else if (cfg_we) begin
      plen <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tready) begin
      r_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_item <= in_item;
    end
  end

  // Read data seen by the executing item
  assign mem_word = mem_zero ? '0 : (mem_byp ? mem_byp_data : mem_q);
  assign rfa_word = rfa_zero ? '0 : (rfa_byp ? rf_byp_data : rfa_q);
  assign rfb_word = rfb_zero ? '0 : (rfb_byp ? rf_byp_data : rfb_q);

  mcc_step u_step (
    .cur      (arch),
    .item     (r_item),
    .plen     (plen),
    .mem_word (mem_word),
    .rf_a     (rfa_word),
    .rf_b     (rfb_word),
    .nxt      (step_arch),
    .mem_wr   (step_mem_wr),
    .rf_wr    (step_rf_wr),
    .res      (step_res)
  );

  assign arch_next = exec_fire ? step_arch : arch;
  assign mem_we    = exec_fire && step_mem_wr.we;
  assign rf_we     = exec_fire && step_rf_wr.we;

  always_ff @(posedge clk) begin
    if (rst) begin
      arch <= mcc_pkg::ARCH_RESET;
    end else begin
      arch <= arch_next;
    end
  end

  // Pick the memory word the incoming item needs, against the state it will see
  always_comb begin
    in_loc    = mcc_pkg::data_loc(arch_next.alu);
    mem_raddr = arch_next.pc[MAW-1:0];
    mem_rok   = int'(arch_next.pc) < mcc_pkg::MEM_DEPTH;
    if (in_item.mode == mcc_pkg::MODE_MEM_RD) begin
      mem_raddr = in_item.addr[MAW-1:0];
      mem_rok   = int'(in_item.addr) < mcc_pkg::MEM_DEPTH;
    end else if (in_item.mode == mcc_pkg::MODE_TICK && arch_next.fsm == mcc_pkg::S_MREAD) begin
      mem_raddr = in_loc.idx;
      mem_rok   = in_loc.ok;
    end
  end

  assign mem_byp_next  = mem_we && (step_mem_wr.addr == mem_raddr);
  assign mem_zero_next = !mem_rok || (!mem_vld[mem_raddr] && !mem_byp_next);

  // Register file addresses: port A serves rs and host reads, port B serves rt
  assign rfa_raddr    = (in_item.mode == mcc_pkg::MODE_REG_RD) ?
                        in_item.addr[RAW-1:0] : arch_next.ir[9+RAW-1:9];
  assign rfb_raddr    = arch_next.ir[6+RAW-1:6];
  assign rfa_byp_next = rf_we && (step_rf_wr.idx == rfa_raddr);
  assign rfb_byp_next = rf_we && (step_rf_wr.idx == rfb_raddr);

  // Capture read qualifiers with the read
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_byp      <= mem_byp_next;
      mem_zero     <= mem_zero_next;
      mem_byp_data <= step_mem_wr.data;
      rfa_byp      <= rfa_byp_next;
      rfb_byp      <= rfb_byp_next;
      rfa_zero     <= !rf_vld[rfa_raddr] && !rfa_byp_next;
      rfb_zero     <= !rf_vld[rfb_raddr] && !rfb_byp_next;
      rf_byp_data  <= step_rf_wr.data;
    end
  end

  // Written-since-reset marks
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_vld <= '0;
      rf_vld  <= '0;
    end else begin
      if (mem_we) begin
        mem_vld[step_mem_wr.addr] <= 1'b1;
      end
      if (rf_we) begin
        rf_vld[step_rf_wr.idx] <= 1'b1;
      end
    end
  end

  mcc_ram #(
    .WIDTH (mcc_pkg::WORD_WIDTH),
    .DEPTH (mcc_pkg::MEM_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (step_mem_wr.addr),
    .wdata (step_mem_wr.data),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  mcc_ram #(
    .WIDTH (mcc_pkg::WORD_WIDTH),
    .DEPTH (mcc_pkg::NUM_REGS)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (step_rf_wr.idx),
    .wdata (step_rf_wr.data),
    .re    (accept),
    .raddr (rfa_raddr),
    .rdata (rfa_q)
  );

  mcc_ram #(
    .WIDTH (mcc_pkg::WORD_WIDTH),
    .DEPTH (mcc_pkg::NUM_REGS)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (step_rf_wr.idx),
    .wdata (step_rf_wr.data),
    .re    (accept),
    .raddr (rfb_raddr),
    .rdata (rfb_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res.read_data, out_res.icnt, out_res.cyc,
                     out_res.mdr, out_res.alu, out_res.ir, out_res.fsm, out_res.pc};
  assign m_tuser  = {out_res.cls, out_res.completed, out_res.halted};

endmodule

`default_nettype wire

// ===== design/mcc_checker.sv =====
// Port-level checker for the multicycle CPU core, bound to the top level.
`default_nettype none

module mcc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [mcc_pkg::M_DATA_W-1:0] m_tdata,
  input wire logic [mcc_pkg::M_USER_W-1:0] m_tuser
);

  logic                      in_fire;
  logic                      out_fire;
  logic [1:0]                pend;
  logic [mcc_pkg::CNT_W-1:0] last_icnt;
  logic [mcc_pkg::CNT_W-1:0] out_icnt;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign out_icnt = m_tdata[123:92];

  // Track items in flight and the last reported instruction count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      last_icnt <= '0;
    end else begin
      pend <= pend + 2'(in_fire) - 2'(out_fire);
      if (out_fire) begin
        last_icnt <= out_icnt;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("report changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != 2'd0 && pend != 2'd3)
    else $error("report without a pending item");

  a_icnt_step: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> out_icnt == last_icnt + mcc_pkg::CNT_W'(m_tuser[1]))
    else $error("instruction count out of step with completions");

endmodule

bind multicycle_cpu_core mcc_checker u_mcc_checker (.*);

`default_nettype wire
